// ----- rtl/ollm_pkg.sv -----
// ----------------------------------------------------------------------------
// Ordinal linked list manager package
// Shared widths, operation and status codes, and the structs that pass
// between the sequencer, the link store and the top level.
// ----------------------------------------------------------------------------
package ollm_pkg;

  localparam int unsigned POOL_SLOTS = 16;
  localparam int unsigned ELEM_W     = 32;
  localparam int unsigned SLOT_W     = $clog2(POOL_SLOTS);
  localparam int unsigned CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned STAT_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_GET    = 3'd2,
    MODE_SET    = 3'd3,
    MODE_CLEAR  = 3'd4
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  // One write into each link array per cycle.
  typedef struct packed {
    logic              nxt_we;
    logic [SLOT_W-1:0] nxt_addr;
    logic [SLOT_W-1:0] nxt_data;
    logic              prv_we;
    logic [SLOT_W-1:0] prv_addr;
    logic [SLOT_W-1:0] prv_data;
  } link_wr_t;

  // Element store access, one address per cycle.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [SLOT_W-1:0] addr;
    logic [ELEM_W-1:0] wdata;
  } mem_cmd_t;

  // Finished item handed from the sequencer to the output register.
  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [CNT_W-1:0] count;
    logic             from_mem;
  } result_t;

endpackage

// ----- rtl/ollm_in_if.sv -----
// ----------------------------------------------------------------------------
// Ordinal linked list manager request channel
// Valid/ready channel carrying one operation item.
// ----------------------------------------------------------------------------
interface ollm_in_if;
  logic                           valid;
  logic                           ready;
  logic [ollm_pkg::MODE_W-1:0]    mode;
  logic [ollm_pkg::SLOT_W-1:0]    index;
  logic [ollm_pkg::ELEM_W-1:0]    write_data;

  modport source (output valid, output mode, output index, output write_data, input ready);
  modport sink   (input valid, input mode, input index, input write_data, output ready);
endinterface

// ----- rtl/ollm_out_if.sv -----
// ----------------------------------------------------------------------------
// Ordinal linked list manager result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface ollm_out_if;
  logic                           valid;
  logic                           ready;
  logic [ollm_pkg::STAT_W-1:0]    status;
  logic [ollm_pkg::ELEM_W-1:0]    read_data;
  logic [ollm_pkg::CNT_W-1:0]     element_count;

  modport source (output valid, output status, output read_data, output element_count,
                  input ready);
  modport sink   (input valid, input status, input read_data, input element_count,
                  output ready);
endinterface

// ----- rtl/ollm_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Ordinal linked list manager configuration channel
// Valid/ready write channel for the slots-in-use register.
// ----------------------------------------------------------------------------
interface ollm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [ollm_pkg::CNT_W-1:0]  slots_in_use;

  modport source (output valid, output slots_in_use, input ready);
  modport sink   (input valid, input slots_in_use, output ready);
endinterface

// ----- rtl/ollm_links.sv -----
// ----------------------------------------------------------------------------
// Ordinal linked list manager link store
// Next and prev link arrays with one shared read address and one write
// into each array per cycle.
// ----------------------------------------------------------------------------
module ollm_links (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [ollm_pkg::SLOT_W-1:0]     rd_addr_i,
  input  ollm_pkg::link_wr_t              wr_i,
  output logic [ollm_pkg::SLOT_W-1:0]     rd_next_o,
  output logic [ollm_pkg::SLOT_W-1:0]     rd_prev_o
);

  logic [ollm_pkg::SLOT_W-1:0] next_q [ollm_pkg::POOL_SLOTS];
  logic [ollm_pkg::SLOT_W-1:0] prev_q [ollm_pkg::POOL_SLOTS];

  // Reset leaves the whole pool as one circular free chain.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ollm_pkg::POOL_SLOTS; i++) begin
        next_q[i] <= ollm_pkg::SLOT_W'(i + 1);
        prev_q[i] <= ollm_pkg::SLOT_W'(i + ollm_pkg::POOL_SLOTS - 1);
      end
    end else begin
      if (wr_i.nxt_we) begin
        next_q[wr_i.nxt_addr] <= wr_i.nxt_data;
      end
      if (wr_i.prv_we) begin
        prev_q[wr_i.prv_addr] <= wr_i.prv_data;
      end
    end
  end

  assign rd_next_o = next_q[rd_addr_i];
  assign rd_prev_o = prev_q[rd_addr_i];

endmodule

// ----- rtl/ollm_seq.sv -----
// ----------------------------------------------------------------------------
// Ordinal linked list manager sequencer
// Walks the used chain one link per cycle through the shared link read
// port and steps through the relinking of add, remove and clear.
// ----------------------------------------------------------------------------
module ollm_seq (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ollm_pkg::MODE_W-1:0]     mode_i,
  input  logic [ollm_pkg::SLOT_W-1:0]     index_i,
  input  logic [ollm_pkg::ELEM_W-1:0]     data_i,
  input  logic [ollm_pkg::CNT_W-1:0]      slots_i,
  input  logic                            out_free_i,
  input  logic [ollm_pkg::SLOT_W-1:0]     rd_next_i,
  input  logic [ollm_pkg::SLOT_W-1:0]     rd_prev_i,
  output logic                            idle_o,
  output logic [ollm_pkg::SLOT_W-1:0]     rd_addr_o,
  output ollm_pkg::link_wr_t              link_wr_o,
  output ollm_pkg::mem_cmd_t              mem_cmd_o,
  output ollm_pkg::result_t               res_o
);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_DECODE = 14'b00000000000010,
    S_WALK   = 14'b00000000000100,
    S_ADD0   = 14'b00000000001000,
    S_ADD1   = 14'b00000000010000,
    S_ADD2   = 14'b00000000100000,
    S_ADD3   = 14'b00000001000000,
    S_REM0   = 14'b00000010000000,
    S_REM1   = 14'b00000100000000,
    S_REM2   = 14'b00001000000000,
    S_CLEAR  = 14'b00010000000000,
    S_DONE   = 14'b00100000000000,
    S_SPARE0 = 14'b01000000000000,
    S_SPARE1 = 14'b10000000000000
  } state_e;

  localparam int unsigned SW = ollm_pkg::SLOT_W;
  localparam int unsigned CW = ollm_pkg::CNT_W;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [CW-1:0]        cap_q, cap_d;
  logic [SW-1:0]        used_head_q, used_head_d;
  logic [SW-1:0]        free_head_q, free_head_d;
  logic                 free_valid_q, free_valid_d;
  logic [SW-1:0]        cur_q, cur_d;
  logic [SW-1:0]        step_q, step_d;
  logic [SW-1:0]        clr_q, clr_d;
  ollm_pkg::status_e    status_q, status_d;
  logic                 from_mem_q, from_mem_d;

  // Item and scratch registers.
  logic [ollm_pkg::MODE_W-1:0] mode_q;
  logic [SW-1:0]               index_q;
  logic [ollm_pkg::ELEM_W-1:0] data_q;
  logic [SW-1:0]               slot_q, slot_d;
  logic [SW-1:0]               tn_q, tn_d;
  logic [SW-1:0]               tp_q, tp_d;

  logic [CW-1:0] clamp_cap;
  logic [CW-1:0] clr_ext;

  always_comb begin
    if (slots_i == '0) begin
      clamp_cap = CW'(1);
    end else if (slots_i > CW'(ollm_pkg::POOL_SLOTS)) begin
      clamp_cap = CW'(ollm_pkg::POOL_SLOTS);
    end else begin
      clamp_cap = slots_i;
    end
  end

  assign clr_ext = {1'b0, clr_q};

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cap_d        = cap_q;
    used_head_d  = used_head_q;
    free_head_d  = free_head_q;
    free_valid_d = free_valid_q;
    cur_d        = cur_q;
    step_d       = step_q;
    clr_d        = clr_q;
    status_d     = status_q;
    from_mem_d   = from_mem_q;
    slot_d       = slot_q;
    tn_d         = tn_q;
    tp_d         = tp_q;
    rd_addr_o    = cur_q;
    link_wr_o    = '0;
    mem_cmd_o    = '0;
    mem_cmd_o.addr  = cur_q;
    mem_cmd_o.wdata = data_q;
    res_o        = '0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          status_d   = ollm_pkg::STAT_OK;
          from_mem_d = 1'b0;
          state_d    = S_DECODE;
        end
      end

      S_DECODE: begin
        cur_d  = used_head_q;
        step_d = '0;
        case (mode_q)
          ollm_pkg::MODE_ADD: begin
            if (count_q >= cap_q) begin
              status_d = ollm_pkg::STAT_FULL;
              state_d  = S_DONE;
            end else begin
              state_d = S_ADD0;
            end
          end
          ollm_pkg::MODE_REMOVE, ollm_pkg::MODE_GET, ollm_pkg::MODE_SET: begin
            if ({1'b0, index_q} >= count_q) begin
              status_d = ollm_pkg::STAT_RANGE;
              state_d  = S_DONE;
            end else begin
              state_d = S_WALK;
            end
          end
          ollm_pkg::MODE_CLEAR: begin
            cap_d        = clamp_cap;
            count_d      = '0;
            used_head_d  = '0;
            free_head_d  = '0;
            free_valid_d = 1'b1;
            clr_d        = '0;
            state_d      = S_CLEAR;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_WALK: begin
        rd_addr_o = cur_q;
        if (step_q == index_q) begin
          case (mode_q)
            ollm_pkg::MODE_REMOVE: begin
              state_d = S_REM0;
            end
            ollm_pkg::MODE_GET: begin
              mem_cmd_o.re = 1'b1;
              from_mem_d   = 1'b1;
              state_d      = S_DONE;
            end
            default: begin
              mem_cmd_o.we = 1'b1;
              state_d      = S_DONE;
            end
          endcase
        end else begin
          cur_d  = rd_next_i;
          step_d = step_q + 1'b1;
        end
      end

      // Take the free head slot and store the element there.
      S_ADD0: begin
        rd_addr_o      = free_head_q;
        slot_d         = free_head_q;
        tn_d           = rd_next_i;
        tp_d           = rd_prev_i;
        mem_cmd_o.we   = 1'b1;
        mem_cmd_o.addr = free_head_q;
        count_d        = count_q + 1'b1;
        state_d        = S_ADD1;
      end

      // Close the free chain around the taken slot, fetch the used tail.
      S_ADD1: begin
        if (count_q < cap_q) begin
          free_head_d         = tn_q;
          link_wr_o.nxt_we    = 1'b1;
          link_wr_o.nxt_addr  = tp_q;
          link_wr_o.nxt_data  = tn_q;
          link_wr_o.prv_we    = 1'b1;
          link_wr_o.prv_addr  = tn_q;
          link_wr_o.prv_data  = tp_q;
        end else begin
          free_valid_d = 1'b0;
        end
        rd_addr_o = used_head_q;
        tp_d      = rd_prev_i;
        state_d   = S_ADD2;
      end

      S_ADD2: begin
        if (count_q > CW'(1)) begin
          link_wr_o.nxt_we   = 1'b1;
          link_wr_o.nxt_addr = tp_q;
          link_wr_o.nxt_data = slot_q;
          link_wr_o.prv_we   = 1'b1;
          link_wr_o.prv_addr = slot_q;
          link_wr_o.prv_data = tp_q;
          state_d            = S_ADD3;
        end else begin
          link_wr_o.nxt_we   = 1'b1;
          link_wr_o.nxt_addr = slot_q;
          link_wr_o.nxt_data = slot_q;
          link_wr_o.prv_we   = 1'b1;
          link_wr_o.prv_addr = slot_q;
          link_wr_o.prv_data = slot_q;
          used_head_d        = slot_q;
          state_d            = S_DONE;
        end
      end

      S_ADD3: begin
        link_wr_o.nxt_we   = 1'b1;
        link_wr_o.nxt_addr = slot_q;
        link_wr_o.nxt_data = used_head_q;
        link_wr_o.prv_we   = 1'b1;
        link_wr_o.prv_addr = used_head_q;
        link_wr_o.prv_data = slot_q;
        state_d            = S_DONE;
      end

      // Unlink the victim from the used chain.
      S_REM0: begin
        rd_addr_o = cur_q;
        count_d   = count_q - 1'b1;
        if (count_q > CW'(1)) begin
          link_wr_o.nxt_we   = 1'b1;
          link_wr_o.nxt_addr = rd_prev_i;
          link_wr_o.nxt_data = rd_next_i;
          link_wr_o.prv_we   = 1'b1;
          link_wr_o.prv_addr = rd_next_i;
          link_wr_o.prv_data = rd_prev_i;
          if (index_q == '0) begin
            used_head_d = rd_next_i;
          end
        end else begin
          used_head_d = '0;
        end
        state_d = S_REM1;
      end

      // Put the victim in front of the free head.
      S_REM1: begin
        if (free_valid_q) begin
          rd_addr_o          = free_head_q;
          tp_d               = rd_prev_i;
          link_wr_o.nxt_we   = 1'b1;
          link_wr_o.nxt_addr = cur_q;
          link_wr_o.nxt_data = free_head_q;
          link_wr_o.prv_we   = 1'b1;
          link_wr_o.prv_addr = cur_q;
          link_wr_o.prv_data = rd_prev_i;
          state_d            = S_REM2;
        end else begin
          link_wr_o.nxt_we   = 1'b1;
          link_wr_o.nxt_addr = cur_q;
          link_wr_o.nxt_data = cur_q;
          link_wr_o.prv_we   = 1'b1;
          link_wr_o.prv_addr = cur_q;
          link_wr_o.prv_data = cur_q;
          free_valid_d       = 1'b1;
          free_head_d        = cur_q;
          state_d            = S_DONE;
        end
      end

      S_REM2: begin
        link_wr_o.prv_we   = 1'b1;
        link_wr_o.prv_addr = free_head_q;
        link_wr_o.prv_data = cur_q;
        link_wr_o.nxt_we   = 1'b1;
        link_wr_o.nxt_addr = tp_q;
        link_wr_o.nxt_data = cur_q;
        free_head_d        = cur_q;
        state_d            = S_DONE;
      end

      // Rebuild one slot per cycle; slots past the capacity point to themselves.
      S_CLEAR: begin
        link_wr_o.nxt_we   = 1'b1;
        link_wr_o.nxt_addr = clr_q;
        link_wr_o.prv_we   = 1'b1;
        link_wr_o.prv_addr = clr_q;
        if (clr_ext < cap_q) begin
          link_wr_o.nxt_data = ((clr_ext + 1'b1) == cap_q) ? '0 : clr_q + 1'b1;
          link_wr_o.prv_data = (clr_q == '0) ? SW'(cap_q - 1'b1) : clr_q - 1'b1;
        end else begin
          link_wr_o.nxt_data = clr_q;
          link_wr_o.prv_data = clr_q;
        end
        if (clr_q == SW'(ollm_pkg::POOL_SLOTS - 1)) begin
          state_d = S_DONE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end

      S_DONE: begin
        res_o.valid    = 1'b1;
        res_o.status   = status_q;
        res_o.count    = count_q;
        res_o.from_mem = from_mem_q;
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign idle_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      cap_q        <= CW'(ollm_pkg::POOL_SLOTS);
      used_head_q  <= '0;
      free_head_q  <= '0;
      free_valid_q <= 1'b1;
      cur_q        <= '0;
      step_q       <= '0;
      clr_q        <= '0;
      status_q     <= ollm_pkg::STAT_OK;
      from_mem_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      cap_q        <= cap_d;
      used_head_q  <= used_head_d;
      free_head_q  <= free_head_d;
      free_valid_q <= free_valid_d;
      cur_q        <= cur_d;
      step_q       <= step_d;
      clr_q        <= clr_d;
      status_q     <= status_d;
      from_mem_q   <= from_mem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && idle_o) begin
      mode_q  <= mode_i;
      index_q <= index_i;
      data_q  <= data_i;
    end
    slot_q <= slot_d;
    tn_q   <= tn_d;
    tp_q   <= tp_d;
  end

  // The element count never passes the latched capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= cap_q)
    else $error("element count above capacity");

  // The capacity stays within the pool.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cap_q != '0) && (cap_q <= CW'(ollm_pkg::POOL_SLOTS)))
    else $error("capacity out of range");

  // Between items the free chain exists exactly when the list is not full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (free_valid_q == (count_q < cap_q)))
    else $error("free chain flag disagrees with count");

  // The walk never steps past the requested position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK) |-> (step_q <= index_q))
    else $error("walk overran its position");

  // An error status only comes from the decode step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (status_q != ollm_pkg::STAT_OK) |-> $past(state_q) != S_WALK)
    else $error("error status after a walk");

endmodule

// ----- rtl/ordinal_linked_list_manager.sv -----
// One item is in work at a time; the request ready stays low until the result
// moves into the output register. Positional operations walk over next links,
// one link per cycle through the single link read port.
// Reset (rst_ni low, asynchronous) empties the list and frees all slots at capacity 16.
// ----------------------------------------------------------------------------
// Ordinal linked list manager
// A pool of slots kept as a free chain and an ordered used chain in link
// arrays, serving add, remove, get, set and clear items.
// ----------------------------------------------------------------------------
module ordinal_linked_list_manager (
  input  logic          clk_i,
  input  logic          rst_ni,
  ollm_in_if.sink       in_i,
  ollm_cfg_if.sink      cfg_i,
  ollm_out_if.source    out_o
);

  logic [ollm_pkg::CNT_W-1:0]   slots_q;
  logic                         seq_idle;
  logic                         out_free;
  logic [ollm_pkg::SLOT_W-1:0]  rd_addr;
  logic [ollm_pkg::SLOT_W-1:0]  rd_next;
  logic [ollm_pkg::SLOT_W-1:0]  rd_prev;
  ollm_pkg::link_wr_t           link_wr;
  ollm_pkg::mem_cmd_t           mem_cmd;
  ollm_pkg::result_t            res;

  // The element store has no reset; get only reaches slots that add wrote.
  logic [ollm_pkg::ELEM_W-1:0]  elem_mem [ollm_pkg::POOL_SLOTS];
  logic [ollm_pkg::ELEM_W-1:0]  mem_rdata_q;

  logic                         out_valid_q;
  logic [ollm_pkg::STAT_W-1:0]  out_status_q;
  logic [ollm_pkg::ELEM_W-1:0]  out_data_q;
  logic [ollm_pkg::CNT_W-1:0]   out_count_q;

  // The register write is always taken. Its value is only latched into the
  // capacity by a clear item, so a write between clears has no effect yet.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slots_q <= ollm_pkg::CNT_W'(ollm_pkg::POOL_SLOTS);
    end else if (cfg_i.valid) begin
      slots_q <= cfg_i.slots_in_use;
    end
  end

  // A new item is taken whenever the sequencer is idle, even while the
  // previous result still waits in the output register.
  assign in_i.ready = seq_idle;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_q || out_o.ready;

  ollm_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_i.valid),
    .mode_i     (in_i.mode),
    .index_i    (in_i.index),
    .data_i     (in_i.write_data),
    .slots_i    (slots_q),
    .out_free_i (out_free),
    .rd_next_i  (rd_next),
    .rd_prev_i  (rd_prev),
    .idle_o     (seq_idle),
    .rd_addr_o  (rd_addr),
    .link_wr_o  (link_wr),
    .mem_cmd_o  (mem_cmd),
    .res_o      (res)
  );

  ollm_links u_links (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .wr_i      (link_wr),
    .rd_next_o (rd_next),
    .rd_prev_o (rd_prev)
  );

  // Single-port element store with a registered read.
  always_ff @(posedge clk_i) begin
    if (mem_cmd.we) begin
      elem_mem[mem_cmd.addr] <= mem_cmd.wdata;
    end
    if (mem_cmd.re) begin
      mem_rdata_q <= elem_mem[mem_cmd.addr];
    end
  end

  // Output register. Read data is zero for everything but a successful get.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && out_free) begin
      out_status_q <= res.status;
      out_data_q   <= res.from_mem ? mem_rdata_q : '0;
      out_count_q  <= res.count;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = out_status_q;
  assign out_o.read_data     = out_data_q;
  assign out_o.element_count = out_count_q;

endmodule
